[hw/rtl/ipv4_longest_prefix_match_macros.svh]
`ifndef IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LPM_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("lpm assertion failed");
`define LPM_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("lpm assertion failed");
`else
`define LPM_ASSERT_SAME(label, clk, rst, cond, conseq)
`define LPM_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif

`endif

[hw/rtl/lpm_pkg.sv]
package lpm_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int OP_W    = 2;
   localparam int ST_W    = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_W-1:0] ST_ZERO      = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  best;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic              free_ok;
      logic [IDX_W-1:0]  free_idx;
   } carry_type;

   typedef struct packed {
      logic              en;
      logic              set;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] network;
      logic [LEN_W-1:0]  len;
   } wr_cmd_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

[hw/rtl/lpm_req_if.sv]
interface lpm_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpm_pkg::OP_W-1:0]      opcode;
   logic [lpm_pkg::ADDR_W-1:0]    address;
   logic [lpm_pkg::LEN_W-1:0]     prefix_len;

   modport source (output valid, output opcode, output address, output prefix_len,
                   input ready);
   modport sink (input valid, input opcode, input address, input prefix_len,
                 output ready);
endinterface

[hw/rtl/lpm_rsp_if.sv]
interface lpm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [lpm_pkg::LEN_W-1:0]  match_len;
   logic [lpm_pkg::ST_W-1:0]   status;

   modport source (output valid, output found, output match_len, output status,
                   input ready);
   modport sink (input valid, input found, input match_len, input status,
                 output ready);
endinterface

[hw/rtl/lpm_cell.sv]
module lpm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lpm_pkg::IDX_W-1:0]  cell_idx,
   input  lpm_pkg::carry_type         up_carry,
   output lpm_pkg::carry_type         down_carry,
   input  lpm_pkg::wr_cmd_type        wr_cmd
);

   logic                        ent_valid_ff;
   logic [lpm_pkg::ADDR_W-1:0]  ent_net_ff;
   logic [lpm_pkg::LEN_W-1:0]   ent_len_ff;
   lpm_pkg::carry_type          carry_ff;
   lpm_pkg::carry_type          carry_in;
   logic [lpm_pkg::ADDR_W-1:0]  net_mask;
   logic                        lookup_hit;
   logic                        exact_hit;
   logic                        wr_here;

   assign net_mask   = lpm_pkg::prefix_mask(ent_len_ff);
   assign lookup_hit = ent_valid_ff && ((up_carry.addr & net_mask) == ent_net_ff) &&
                       (ent_len_ff > up_carry.best);
   assign exact_hit  = ent_valid_ff && (ent_len_ff == up_carry.len) &&
                       (ent_net_ff == up_carry.addr);
   assign wr_here    = wr_cmd.en && (wr_cmd.idx == cell_idx);

   always_comb begin
      carry_in = up_carry;
      if (up_carry.op == lpm_pkg::OP_LOOKUP) begin
         if (lookup_hit) begin
            carry_in.best = ent_len_ff;
         end
      end else if (exact_hit) begin
         carry_in.hit     = 1'b1;
         carry_in.hit_idx = cell_idx;
      end
      if (!ent_valid_ff && !up_carry.free_ok) begin
         carry_in.free_ok  = 1'b1;
         carry_in.free_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.valid <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (wr_here) begin
         ent_valid_ff <= wr_cmd.set;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here && wr_cmd.set) begin
         ent_net_ff <= wr_cmd.network;
         ent_len_ff <= wr_cmd.len;
      end
   end

   assign down_carry = carry_ff;

endmodule

[hw/rtl/ipv4_longest_prefix_match.sv]
// channel | dir | handshake          | payload
// req_if  | in  | valid/ready        | opcode, address, prefix_len
// rsp_if  | out | valid/ready        | found, match_len, status
//
// One item at a time: an item passes a load stage, the 64-cell chain that it walks
// one cell per cycle, and a result stage.
// req_if.ready is low from accept until the result enters the output register.
// A result held by rsp_if.ready low holds the next item in the result stage.
// Synchronous reset clears every entry valid bit.
`include "ipv4_longest_prefix_match_macros.svh"

module ipv4_longest_prefix_match (
   input logic        clock,
   input logic        reset,
   lpm_req_if.sink    req_if,
   lpm_rsp_if.source  rsp_if
);

   logic                       req_take;
   logic                       busy_ff;
   logic                       busy_in;
   lpm_pkg::carry_type         head_ff;
   lpm_pkg::carry_type         head_in;
   lpm_pkg::carry_type         pend_ff;
   lpm_pkg::carry_type         chain [lpm_pkg::ENTRIES+1];
   lpm_pkg::wr_cmd_type        wr_cmd;
   logic                       issue;
   logic                       bad_len;
   logic                       rs_found;
   logic [lpm_pkg::LEN_W-1:0]  rs_len;
   logic [lpm_pkg::ST_W-1:0]   rs_status;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_found_ff;
   logic [lpm_pkg::LEN_W-1:0]  rsp_len_ff;
   logic [lpm_pkg::ST_W-1:0]   rsp_status_ff;

   assign req_if.ready = !busy_ff;
   assign req_take     = req_if.valid && !busy_ff;

   always_comb begin
      head_in          = '0;
      head_in.valid    = 1'b1;
      head_in.op       = req_if.opcode;
      head_in.len      = req_if.prefix_len;
      head_in.addr     = (req_if.opcode == lpm_pkg::OP_LOOKUP) ? req_if.address :
                         (req_if.address & lpm_pkg::prefix_mask(req_if.prefix_len));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (req_take) begin
         head_ff <= head_in;
      end else begin
         head_ff.valid <= 1'b0;
      end
   end

   assign chain[0] = head_ff;

   for (genvar k = 0; k < lpm_pkg::ENTRIES; k++) begin : g_cell
      lpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (lpm_pkg::IDX_W'(k)),
         .up_carry   (chain[k]),
         .down_carry (chain[k+1]),
         .wr_cmd     (wr_cmd)
      );
   end

   assign issue = pend_ff.valid && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff.valid <= 1'b0;
      end else if (chain[lpm_pkg::ENTRIES].valid) begin
         pend_ff <= chain[lpm_pkg::ENTRIES];
      end else if (issue) begin
         pend_ff.valid <= 1'b0;
      end
   end

   assign bad_len = (pend_ff.len == '0) ||
                    (pend_ff.len > lpm_pkg::LEN_W'(lpm_pkg::ADDR_W));

   always_comb begin
      rs_found       = 1'b0;
      rs_len         = '0;
      rs_status      = lpm_pkg::ST_NOT_FOUND;
      wr_cmd         = '0;
      wr_cmd.network = pend_ff.addr;
      wr_cmd.len     = pend_ff.len;
      unique case (pend_ff.op)
         lpm_pkg::OP_LOOKUP: begin
            if (pend_ff.addr == '0) begin
               rs_status = lpm_pkg::ST_ZERO;
            end else if (pend_ff.best != '0) begin
               rs_found  = 1'b1;
               rs_len    = pend_ff.best;
               rs_status = lpm_pkg::ST_OK;
            end
         end
         lpm_pkg::OP_INSERT: begin
            if (!bad_len) begin
               if (pend_ff.hit) begin
                  rs_status = lpm_pkg::ST_OK;
               end else if (pend_ff.free_ok) begin
                  rs_status  = lpm_pkg::ST_OK;
                  wr_cmd.en  = issue;
                  wr_cmd.set = 1'b1;
                  wr_cmd.idx = pend_ff.free_idx;
               end else begin
                  rs_status = lpm_pkg::ST_FULL;
               end
            end
         end
         lpm_pkg::OP_REMOVE: begin
            if (!bad_len && pend_ff.hit) begin
               rs_found   = 1'b1;
               rs_status  = lpm_pkg::ST_OK;
               wr_cmd.en  = issue;
               wr_cmd.idx = pend_ff.hit_idx;
            end
         end
         lpm_pkg::OP_UNUSED: begin
            rs_status = lpm_pkg::ST_NOT_FOUND;
         end
         default: begin
            rs_status = lpm_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   assign busy_in      = req_take || (busy_ff && !issue);
   assign rsp_valid_in = issue || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_found_ff  <= rs_found;
         rsp_len_ff    <= rs_len;
         rsp_status_ff <= rs_status;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.found     = rsp_found_ff;
   assign rsp_if.match_len = rsp_len_ff;
   assign rsp_if.status    = rsp_status_ff;

   `LPM_ASSERT_NEXT(a_accept_loads, clock, reset, req_take, busy_ff && head_ff.valid)
   `LPM_ASSERT_SAME(a_one_item, clock, reset, pend_ff.valid, !head_ff.valid)
   `LPM_ASSERT_NEXT(a_issue_frees, clock, reset, issue, !busy_ff && rsp_valid_ff)
   `LPM_ASSERT_SAME(a_write_on_issue, clock, reset, wr_cmd.en, issue && busy_ff)

endmodule
